/* src/frx_pkg.sv */
// Shared types, constants and helpers of the flash update receiver.
package frx_pkg;

	// Store geometry
	localparam int unsigned PAGE_BYTES  = 256;
	localparam int unsigned STORE_BYTES = 65536;
	localparam int unsigned ADDR_W      = $clog2(STORE_BYTES);
	localparam int unsigned OFF_W       = $clog2(PAGE_BYTES + 1);
	localparam int unsigned CNT_W       = 32;
	localparam int unsigned PSTART_W    = CNT_W + 1;

	// Result queue geometry
	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
	localparam int unsigned LVL_W      = $clog2(FIFO_DEPTH + 1);
	localparam int unsigned MAX_RES    = 3;

	// Protocol framing
	localparam int unsigned HDR_LEN    = 6;
	localparam int unsigned SIZE_BYTES = 4;

	// Link byte codes
	localparam logic [7:0] HDR_FIRST      = 8'h13;
	localparam logic [7:0] HDR_DATA_END   = 8'h18;
	localparam logic [7:0] HDR_VERIFY_END = 8'h19;
	localparam logic [7:0] HDR_COMMIT_END = 8'h20;
	localparam logic [7:0] RSP_OK         = 8'hF0;
	localparam logic [7:0] RSP_FAIL       = 8'hF1;
	localparam logic [7:0] RSP_PAGE       = 8'h13;
	localparam logic [7:0] RSP_COMMIT_A   = 8'h15;
	localparam logic [7:0] RSP_COMMIT_B   = 8'h16;
	localparam logic [7:0] PAD_BYTE       = 8'hFF;

	typedef struct packed {
		logic       mode;
		logic [7:0] rx_byte;
	} frx_in_t;

	typedef struct packed {
		logic [7:0] reply_byte;
		logic       last_of_run;
		logic       commit;
		logic       failed;
	} frx_out_t;

	typedef struct packed {
		logic     valid;
		frx_out_t data;
	} frx_push_t;

	typedef struct packed {
		logic              we;
		logic              re;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        wdata;
	} frx_mem_t;

	// Expected header byte at a given position
	function automatic logic [7:0] hdr_want(input logic [2:0] idx, input logic [7:0] last_byte);
		logic [7:0] w;
		if (idx < 3'(HDR_LEN - 1)) begin
			w = HDR_FIRST + {5'b0, idx};
		end else begin
			w = last_byte;
		end
		return w;
	endfunction

endpackage

/* src/flash_update_receiver.sv */
// Top level of the flash update receiver: sequencer, staging store and result queue.
//
//  channel | direction | handshake            | payload
//  cmd     | in        | cmd_valid, cmd_stall | cmd: mode, rx_byte
//  rsp     | out       | rsp_valid, rsp_stall | rsp: reply_byte, last_of_run, commit, failed
//
// Header and size bytes are taken in the idle state; an image byte then passes
// through the read stage, which writes it (data) or compares it with the store
// read issued on acceptance (verify) on the single store port. Each reply is
// pushed into the four-entry result queue. A short data page is filled with pad
// bytes, at most PAGE_BYTES - 1. An accepted commit header adds an erase sweep of
// the whole store. arst_n clears all control state; the store needs no clearing
// pass. A stalled reply channel holds new requests only once the queue is full.
module flash_update_receiver
	import frx_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	output logic     cmd_stall,
	input  frx_in_t  cmd,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output frx_out_t rsp
);

	frx_push_t  push;
	logic       fifo_full;
	frx_mem_t   mem;
	logic [7:0] mem_rdata;

	// Sequencer
	frx_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.push      (push),
		.fifo_full (fifo_full),
		.mem       (mem),
		.mem_rdata (mem_rdata)
	);

	// Staging store
	frx_ram #(
		.DEPTH (STORE_BYTES),
		.WIDTH (8)
	) u_store (
		.clk   (clk),
		.we    (mem.we),
		.re    (mem.re),
		.addr  (mem.addr),
		.wdata (mem.wdata),
		.rdata (mem_rdata)
	);

	// Result queue
	frx_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (fifo_full),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> !fifo_full)
		else $error("result pushed into a full queue");

	a_single_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem.we && mem.re))
		else $error("store read and write in the same cycle");

	a_commit_reply: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.commit |-> rsp.reply_byte == RSP_OK && !rsp.failed && !rsp.last_of_run)
		else $error("commit flag on a wrong reply");

	a_fail_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.failed |-> rsp.reply_byte == RSP_FAIL && rsp.last_of_run)
		else $error("failure reply not final");
`endif

endmodule

/* src/frx_ram.sv */
// Single-port synchronous RAM with registered read data.
module frx_ram #(
	parameter int unsigned DEPTH = 256,
	parameter int unsigned WIDTH = 8,
	localparam int unsigned AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic             re,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write or read one entry per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

/* src/frx_fifo.sv */
// Result queue between the sequencer and the reply channel.
module frx_fifo
	import frx_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  frx_push_t push,
	output logic      full,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output frx_out_t  rsp
);

	frx_out_t          slot_q [FIFO_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [LVL_W-1:0]  level_q;
	logic              pop;

	assign full      = (level_q == LVL_W'(FIFO_DEPTH));
	assign rsp_valid = (level_q != '0);
	assign rsp       = slot_q[rd_ptr_q];
	assign pop       = rsp_valid && !rsp_stall;

	// Store pushed results
	always_ff @(posedge clk) begin
		if (push.valid) begin
			slot_q[wr_ptr_q] <= push.data;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push.valid && !pop) begin
				level_q <= level_q + 1'b1;
			end else if (pop && !push.valid) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

endmodule

/* src/frx_ctrl.sv */
// Session sequencer: header checks, paging, verify compare, padding and erase sweeps.
module frx_ctrl
	import frx_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_stall,
	input  frx_in_t    cmd,
	output frx_push_t  push,
	input  logic       fifo_full,
	output frx_mem_t   mem,
	input  logic [7:0] mem_rdata
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_READ  = 5'b00010,
		ST_EMIT  = 5'b00100,
		ST_PAD   = 5'b01000,
		ST_ERASE = 5'b10000
	} frx_st_t;

	typedef enum logic [6:0] {
		PH_IDLE       = 7'b0000001,
		PH_HDR_DATA   = 7'b0000010,
		PH_SIZE       = 7'b0000100,
		PH_DATA       = 7'b0001000,
		PH_HDR_VERIFY = 7'b0010000,
		PH_VERIFY     = 7'b0100000,
		PH_HDR_COMMIT = 7'b1000000
	} frx_phase_t;

	typedef struct packed {
		logic [7:0] reply_byte;
		logic       commit;
		logic       failed;
	} frx_res_t;

	localparam frx_res_t RES_OK       = '{RSP_OK, 1'b0, 1'b0};
	localparam frx_res_t RES_FAIL     = '{RSP_FAIL, 1'b0, 1'b1};
	localparam frx_res_t RES_PAGE     = '{RSP_PAGE, 1'b0, 1'b0};
	localparam frx_res_t RES_COMMIT   = '{RSP_OK, 1'b1, 1'b0};
	localparam frx_res_t RES_COMMIT_A = '{RSP_COMMIT_A, 1'b0, 1'b0};
	localparam frx_res_t RES_COMMIT_B = '{RSP_COMMIT_B, 1'b0, 1'b0};

	frx_st_t             st_q;
	frx_st_t             after_q;
	frx_phase_t          phase_q;
	logic [2:0]          hidx_q;
	logic [CNT_W-1:0]    image_size_q;
	logic [CNT_W-1:0]    byte_count_q;
	logic                good_q;
	logic [PSTART_W-1:0] page_start_q;
	logic [PSTART_W-1:0] page_end_q;
	logic [OFF_W-1:0]    off_q;
	logic [7:0]          rx_q;
	frx_res_t            res_q [MAX_RES];
	logic [1:0]          res_n_q;
	logic [1:0]          emit_idx_q;
	logic [ADDR_W:0]     pad_addr_q;
	logic [ADDR_W-1:0]   erase_addr_q;

	logic                accept;
	logic [7:0]          hdr_final;
	logic                hdr_good_nx;
	logic                hdr_done;
	logic [CNT_W-1:0]    size_nx;
	logic [PSTART_W-1:0] page_lim;
	logic [PSTART_W-1:0] page_end_c;
	logic                fits;
	logic [CNT_W-1:0]    cnt_nx;
	logic [OFF_W-1:0]    off_nx;
	logic                at_page_end;
	logic                at_image_end;
	logic                verify_good_nx;
	logic                pad_needed;
	logic [ADDR_W:0]     pad_addr_nx;
	logic                pad_last;
	logic                emit_last;

	assign cmd_stall = (st_q != ST_IDLE);
	assign accept    = cmd_valid && (st_q == ST_IDLE);

	// Header byte check
	always_comb begin
		if (phase_q == PH_HDR_DATA) begin
			hdr_final = HDR_DATA_END;
		end else if (phase_q == PH_HDR_VERIFY) begin
			hdr_final = HDR_VERIFY_END;
		end else begin
			hdr_final = HDR_COMMIT_END;
		end
	end
	assign hdr_good_nx = good_q && (cmd.rx_byte == hdr_want(hidx_q, hdr_final));
	assign hdr_done    = (hidx_q == 3'(HDR_LEN - 1));
	assign size_nx     = {image_size_q[CNT_W-9:0], cmd.rx_byte};

	// Page bounds: end is the smaller of page limit and image size
	assign page_lim   = page_start_q + PSTART_W'(PAGE_BYTES);
	assign page_end_c = (page_lim < {1'b0, image_size_q}) ? page_lim : {1'b0, image_size_q};
	assign fits       = (page_end_q <= PSTART_W'(STORE_BYTES));

	// Byte bookkeeping in the read stage
	assign cnt_nx         = byte_count_q + 1'b1;
	assign off_nx         = off_q + 1'b1;
	assign at_page_end    = ({1'b0, cnt_nx} == page_end_q);
	assign at_image_end   = (cnt_nx == image_size_q);
	assign verify_good_nx = good_q && !((phase_q == PH_VERIFY) && fits && (mem_rdata != rx_q));
	assign pad_needed     = (phase_q == PH_DATA) && fits && (off_nx != OFF_W'(PAGE_BYTES))
	                        && (page_end_q < PSTART_W'(STORE_BYTES));

	// Padding sweep bounds
	assign pad_addr_nx = pad_addr_q + 1'b1;
	assign pad_last    = (off_nx == OFF_W'(PAGE_BYTES)) || (pad_addr_nx == (ADDR_W+1)'(STORE_BYTES));

	// Result push
	assign emit_last              = (emit_idx_q == (res_n_q - 2'd1));
	assign push.valid             = (st_q == ST_EMIT) && !fifo_full;
	assign push.data.reply_byte   = res_q[emit_idx_q].reply_byte;
	assign push.data.last_of_run  = emit_last;
	assign push.data.commit       = res_q[emit_idx_q].commit;
	assign push.data.failed       = res_q[emit_idx_q].failed;

	// Store port: data write, verify read, pad and erase sweeps
	always_comb begin
		mem.we    = 1'b0;
		mem.re    = accept && cmd.mode && (phase_q == PH_VERIFY);
		mem.addr  = byte_count_q[ADDR_W-1:0];
		mem.wdata = PAD_BYTE;
		if (st_q == ST_READ) begin
			mem.we    = (phase_q == PH_DATA) && fits;
			mem.wdata = rx_q;
		end else if (st_q == ST_PAD) begin
			mem.we   = 1'b1;
			mem.addr = pad_addr_q[ADDR_W-1:0];
		end else if (st_q == ST_ERASE) begin
			mem.we   = 1'b1;
			mem.addr = erase_addr_q;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_IDLE;
			after_q      <= ST_IDLE;
			phase_q      <= PH_IDLE;
			hidx_q       <= '0;
			image_size_q <= '0;
			byte_count_q <= '0;
			good_q       <= 1'b1;
			page_start_q <= '0;
			page_end_q   <= '0;
			off_q        <= '0;
			rx_q         <= '0;
			for (int i = 0; i < MAX_RES; i++) begin
				res_q[i] <= RES_OK;
			end
			res_n_q      <= '0;
			emit_idx_q   <= '0;
			pad_addr_q   <= '0;
			erase_addr_q <= '0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (accept) begin
						if (!cmd.mode) begin
							// Begin a session from any phase
							phase_q      <= PH_HDR_DATA;
							hidx_q       <= '0;
							good_q       <= 1'b1;
							byte_count_q <= '0;
							page_start_q <= '0;
							off_q        <= '0;
							res_q[0]     <= RES_OK;
							res_n_q      <= 2'd1;
							after_q      <= ST_IDLE;
							st_q         <= ST_EMIT;
						end else begin
							unique case (phase_q) inside
								PH_IDLE: begin
									phase_q <= PH_IDLE;
								end
								PH_HDR_DATA, PH_HDR_VERIFY, PH_HDR_COMMIT: begin
									good_q <= hdr_good_nx;
									hidx_q <= hidx_q + 3'd1;
									if (hdr_done) begin
										hidx_q  <= '0;
										res_n_q <= 2'd1;
										after_q <= ST_IDLE;
										st_q    <= ST_EMIT;
										if (!hdr_good_nx) begin
											res_q[0] <= RES_FAIL;
											phase_q  <= PH_IDLE;
										end else if (phase_q == PH_HDR_DATA) begin
											res_q[0]     <= RES_OK;
											image_size_q <= '0;
											phase_q      <= PH_SIZE;
										end else if (phase_q == PH_HDR_VERIFY) begin
											res_q[0]     <= RES_OK;
											byte_count_q <= '0;
											page_start_q <= '0;
											off_q        <= '0;
											if (image_size_q == '0) begin
												res_q[1] <= RES_OK;
												res_n_q  <= 2'd2;
												good_q   <= 1'b1;
												phase_q  <= PH_HDR_COMMIT;
											end else begin
												phase_q <= PH_VERIFY;
											end
										end else begin
											// Commit accepted: report, then erase the store
											res_q[0]     <= RES_COMMIT;
											res_q[1]     <= RES_COMMIT_A;
											res_q[2]     <= RES_COMMIT_B;
											res_n_q      <= 2'd3;
											phase_q      <= PH_IDLE;
											good_q       <= 1'b1;
											byte_count_q <= '0;
											page_start_q <= '0;
											off_q        <= '0;
											after_q      <= ST_ERASE;
										end
									end
								end
								PH_SIZE: begin
									image_size_q <= size_nx;
									hidx_q       <= hidx_q + 3'd1;
									if (hidx_q == 3'(SIZE_BYTES - 1)) begin
										hidx_q       <= '0;
										byte_count_q <= '0;
										page_start_q <= '0;
										off_q        <= '0;
										res_q[0]     <= RES_OK;
										res_n_q      <= 2'd1;
										after_q      <= ST_IDLE;
										st_q         <= ST_EMIT;
										if (size_nx == '0) begin
											res_q[1] <= RES_OK;
											res_n_q  <= 2'd2;
											good_q   <= 1'b1;
											phase_q  <= PH_HDR_VERIFY;
										end else begin
											phase_q <= PH_DATA;
										end
									end
								end
								PH_DATA, PH_VERIFY: begin
									rx_q       <= cmd.rx_byte;
									page_end_q <= page_end_c;
									st_q       <= ST_READ;
								end
								default: begin
									phase_q <= PH_IDLE;
								end
							endcase
						end
					end
				end
				ST_READ: begin
					// Write or compare one image byte; at a page end, close the page
					good_q       <= verify_good_nx;
					byte_count_q <= cnt_nx;
					off_q        <= off_nx;
					st_q         <= ST_IDLE;
					if (at_page_end) begin
						page_start_q <= page_lim;
						res_q[0]     <= RES_PAGE;
						res_n_q      <= 2'd1;
						pad_addr_q   <= page_end_q[ADDR_W:0];
						st_q         <= ST_EMIT;
						if (pad_needed) begin
							after_q <= ST_PAD;
						end else begin
							after_q <= ST_IDLE;
							off_q   <= '0;
						end
						if (at_image_end) begin
							res_n_q <= 2'd2;
							if (phase_q == PH_DATA) begin
								res_q[1] <= RES_OK;
								phase_q  <= PH_HDR_VERIFY;
								hidx_q   <= '0;
								good_q   <= 1'b1;
							end else if (verify_good_nx) begin
								res_q[1] <= RES_OK;
								phase_q  <= PH_HDR_COMMIT;
								hidx_q   <= '0;
								good_q   <= 1'b1;
							end else begin
								res_q[1] <= RES_FAIL;
								phase_q  <= PH_IDLE;
								hidx_q   <= '0;
							end
						end
					end
				end
				ST_EMIT: begin
					// Hand results to the queue one per cycle while the queue is not full
					if (!fifo_full) begin
						if (emit_last) begin
							emit_idx_q <= '0;
							st_q       <= after_q;
						end else begin
							emit_idx_q <= emit_idx_q + 2'd1;
						end
					end
				end
				ST_PAD: begin
					// Fill the rest of a short page
					pad_addr_q <= pad_addr_nx;
					off_q      <= off_nx;
					if (pad_last) begin
						off_q <= '0;
						st_q  <= ST_IDLE;
					end
				end
				ST_ERASE: begin
					// Sweep the whole store
					if (erase_addr_q == ADDR_W'(STORE_BYTES - 1)) begin
						erase_addr_q <= '0;
						st_q         <= ST_IDLE;
					end else begin
						erase_addr_q <= erase_addr_q + 1'b1;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* test/tb_top.sv */
// Self-checking testbench of the flash update receiver: directed and random link sessions against a predictor.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import frx_pkg::*;

	localparam int RANDOM_ITEMS = 160;
	localparam int BURST_ITEMS  = 10;
	localparam int LONG_HOLD    = 400;
	localparam int DRAIN_CYCLES = STORE_BYTES + 300;
	localparam longint LIMIT_CYCLES = 64'd16_000_000;

	typedef enum {
		FLT_NONE, FLT_DATA_HDR, FLT_VERIFY_HDR, FLT_VERIFY_DATA, FLT_COMMIT_HDR, FLT_SKIP_COMMIT
	} session_fault_e;

	// Predict the replies of each accepted request and compare them in order
	class reply_scoreboard;
		typedef enum logic [2:0] {
			PH_IDLE, PH_HDR_DATA, PH_SIZE, PH_DATA, PH_HDR_VERIFY, PH_VERIFY, PH_HDR_COMMIT
		} link_phase_e;
		typedef enum {HDR_MORE, HDR_GOOD, HDR_BAD} hdr_status_e;

		link_phase_e phase;
		logic [2:0]  hdr_idx;
		logic [31:0] image_size;
		logic [31:0] byte_count;
		logic        hdr_ok;
		logic [7:0]  staging[STORE_BYTES];
		frx_out_t    expected_replies[$];
		int errors, requests, checked, pages, commits, aborts;

		function new();
			phase      = PH_IDLE;
			hdr_idx    = '0;
			image_size = '0;
			byte_count = '0;
			hdr_ok     = 1'b1;
			errors     = 0;
			requests   = 0;
			checked    = 0;
			pages      = 0;
			commits    = 0;
			aborts     = 0;
		endfunction

		function int pending();
			return expected_replies.size();
		endfunction

		function void push_reply(input logic [7:0] code, input logic commit_flag,
				input logic fail_flag);
			frx_out_t r;
			r.reply_byte  = code;
			r.last_of_run = 1'b0;
			r.commit      = commit_flag;
			r.failed      = fail_flag;
			expected_replies.push_back(r);
		endfunction

		function void open_header(input link_phase_e nxt);
			phase   = nxt;
			hdr_idx = '0;
			hdr_ok  = 1'b1;
		endfunction

		// Answer fail and drop back to idle
		function void abort();
			push_reply(RSP_FAIL, 1'b0, 1'b1);
			phase   = PH_IDLE;
			hdr_idx = '0;
			aborts++;
		endfunction

		// Match one header byte; report once all six are in
		function hdr_status_e header_step(input logic [7:0] b, input logic [7:0] last_byte);
			logic [7:0] want;
			want = (hdr_idx < HDR_LEN - 1) ? HDR_FIRST + 8'(hdr_idx) : last_byte;
			if (b != want) hdr_ok = 1'b0;
			hdr_idx++;
			if (hdr_idx < HDR_LEN) return HDR_MORE;
			hdr_idx = '0;
			return hdr_ok ? HDR_GOOD : HDR_BAD;
		endfunction

		function void note_request(input frx_in_t req);
			int              n0;
			logic [7:0]      b;
			longint unsigned bc, pg_start, pg_len, remain, addr;
			bit              fits;
			hdr_status_e     hs;
			frx_out_t        tail;
			n0 = expected_replies.size();
			b  = req.rx_byte;
			requests++;
			if (req.mode == 1'b0) begin
				open_header(PH_HDR_DATA);
				byte_count = '0;
				push_reply(RSP_OK, 1'b0, 1'b0);
			end else begin
				case (phase)
					PH_HDR_DATA: begin
						hs = header_step(b, HDR_DATA_END);
						if (hs == HDR_BAD) begin
							abort();
						end else if (hs == HDR_GOOD) begin
							phase      = PH_SIZE;
							image_size = '0;
							push_reply(RSP_OK, 1'b0, 1'b0);
						end
					end
					PH_SIZE: begin
						image_size = {image_size[23:0], b};
						hdr_idx++;
						if (hdr_idx >= SIZE_BYTES) begin
							hdr_idx    = '0;
							byte_count = '0;
							push_reply(RSP_OK, 1'b0, 1'b0);
							if (image_size == 0) begin
								push_reply(RSP_OK, 1'b0, 1'b0);
								open_header(PH_HDR_VERIFY);
							end else begin
								phase = PH_DATA;
							end
						end
					end
					PH_DATA, PH_VERIFY: begin
						// Locate the page and whether it lies inside the store
						bc       = byte_count;
						pg_start = bc - bc % PAGE_BYTES;
						remain   = longint'(image_size) - pg_start;
						pg_len   = (remain > PAGE_BYTES) ? PAGE_BYTES : remain;
						fits     = (pg_start + pg_len) <= STORE_BYTES;
						if (fits && bc < STORE_BYTES) begin
							if (phase == PH_DATA) begin
								staging[bc] = b;
							end else if (staging[bc] != b) begin
								hdr_ok = 1'b0;
							end
						end
						byte_count++;
						if (longint'(byte_count) == pg_start + pg_len) begin
							// Pad the tail of a short page
							if (phase == PH_DATA && fits) begin
								for (addr = pg_start + pg_len;
										addr < pg_start + PAGE_BYTES && addr < STORE_BYTES;
										addr++)
									staging[addr] = PAD_BYTE;
							end
							push_reply(RSP_PAGE, 1'b0, 1'b0);
							pages++;
							if (byte_count == image_size) begin
								if (phase == PH_DATA) begin
									push_reply(RSP_OK, 1'b0, 1'b0);
									open_header(PH_HDR_VERIFY);
								end else if (hdr_ok) begin
									push_reply(RSP_OK, 1'b0, 1'b0);
									open_header(PH_HDR_COMMIT);
								end else begin
									abort();
								end
							end
						end
					end
					PH_HDR_VERIFY: begin
						hs = header_step(b, HDR_VERIFY_END);
						if (hs == HDR_BAD) begin
							abort();
						end else if (hs == HDR_GOOD) begin
							byte_count = '0;
							push_reply(RSP_OK, 1'b0, 1'b0);
							if (image_size == 0) begin
								push_reply(RSP_OK, 1'b0, 1'b0);
								open_header(PH_HDR_COMMIT);
							end else begin
								phase = PH_VERIFY;
							end
						end
					end
					PH_HDR_COMMIT: begin
						hs = header_step(b, HDR_COMMIT_END);
						if (hs == HDR_BAD) begin
							abort();
						end else if (hs == HDR_GOOD) begin
							push_reply(RSP_OK, 1'b1, 1'b0);
							push_reply(RSP_COMMIT_A, 1'b0, 1'b0);
							push_reply(RSP_COMMIT_B, 1'b0, 1'b0);
							// Erase the staging store
							foreach (staging[a]) staging[a] = PAD_BYTE;
							phase      = PH_IDLE;
							hdr_idx    = '0;
							byte_count = '0;
							hdr_ok     = 1'b1;
							commits++;
						end
					end
					default: begin
						phase = PH_IDLE;
					end
				endcase
			end
			// Mark the final reply of this request
			if (expected_replies.size() > n0) begin
				tail = expected_replies.pop_back();
				tail.last_of_run = 1'b1;
				expected_replies.push_back(tail);
			end
		endfunction

		function void check_reply(input frx_out_t got);
			frx_out_t want;
			if (expected_replies.size() == 0) begin
				$error("unexpected reply: reply_byte %h", got.reply_byte);
				errors++;
				return;
			end
			want = expected_replies.pop_front();
			checked++;
			if (got.reply_byte !== want.reply_byte) begin
				$error("reply_byte: expected %h, got %h", want.reply_byte, got.reply_byte);
				errors++;
			end
			if (got.last_of_run !== want.last_of_run) begin
				$error("last_of_run: expected %b, got %b", want.last_of_run, got.last_of_run);
				errors++;
			end
			if (got.commit !== want.commit) begin
				$error("commit: expected %b, got %b", want.commit, got.commit);
				errors++;
			end
			if (got.failed !== want.failed) begin
				$error("failed: expected %b, got %b", want.failed, got.failed);
				errors++;
			end
		endfunction
	endclass

	logic     clk;
	logic     arst_n    = 1'b0;
	logic     cmd_valid = 1'b0;
	logic     cmd_stall;
	frx_in_t  cmd       = '0;
	logic     rsp_valid;
	logic     rsp_stall = 1'b0;
	frx_out_t rsp;

	reply_scoreboard sb;
	logic [7:0] image_data[$];
	int     sent_items    = 0;
	int     hold_requests = 0;
	int     holds_done    = 0;
	bit     tx_quiet      = 1'b0;
	bit     rx_quiet      = 1'b0;
	longint cycles        = 0;

	flash_update_receiver dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Draw an idle gap; quiet stretches run without gaps
	function automatic int pick_gap(input bit quiet);
		return quiet ? 0 : $urandom_range(0, 13);
	endfunction

	// Offer one request and hold it until accepted; returns on a falling edge
	task automatic send_request(input logic m, input logic [7:0] b);
		int      gap;
		frx_in_t req;
		req.mode    = m;
		req.rx_byte = b;
		if ($urandom_range(0, 23) == 0) tx_quiet = !tx_quiet;
		gap = pick_gap(tx_quiet);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= req;
		do @(posedge clk); while (cmd_stall !== 1'b0);
		sb.note_request(req);
		sent_items++;
		@(negedge clk);
	endtask

	task automatic send_header(input logic [7:0] last_byte, input bit spoil);
		int         spoil_at;
		logic [7:0] hb;
		spoil_at = spoil ? int'($urandom_range(0, HDR_LEN - 1)) : -1;
		for (int i = 0; i < HDR_LEN; i++) begin
			hb = (i < HDR_LEN - 1) ? HDR_FIRST + 8'(i) : last_byte;
			if (i == spoil_at) hb = hb ^ 8'($urandom_range(1, 255));
			send_request(1'b1, hb);
		end
	endtask

	// Send the image size big-endian
	task automatic send_size(input logic [31:0] size);
		for (int i = SIZE_BYTES - 1; i >= 0; i--)
			send_request(1'b1, size[8*i +: 8]);
	endtask

	task automatic send_image(input int bad_at);
		logic [7:0] b;
		foreach (image_data[i]) begin
			b = image_data[i];
			if (i == bad_at) b = b ^ 8'($urandom_range(1, 255));
			send_request(1'b1, b);
		end
	endtask

	// Walk one update session, stopping where the fault breaks it
	task automatic run_session(input logic [31:0] size, input session_fault_e fault);
		int bad_at;
		int fit;
		send_request(1'b0, 8'($urandom));
		send_header(HDR_DATA_END, fault == FLT_DATA_HDR);
		if (fault == FLT_DATA_HDR) return;
		send_size(size);
		image_data.delete();
		repeat (size) image_data.push_back(8'($urandom));
		send_image(-1);
		send_header(HDR_VERIFY_END, fault == FLT_VERIFY_HDR);
		if (fault == FLT_VERIFY_HDR) return;
		fit    = (size < STORE_BYTES) ? int'(size) : STORE_BYTES;
		bad_at = (fault == FLT_VERIFY_DATA && fit > 0) ? int'($urandom_range(0, fit - 1)) : -1;
		send_image(bad_at);
		if (fault == FLT_VERIFY_DATA || fault == FLT_SKIP_COMMIT) return;
		send_header(HDR_COMMIT_END, fault == FLT_COMMIT_HDR);
	endtask

	// Take replies with random stalls, and hold off for a long stretch on request
	task automatic serve_replies();
		int gap;
		forever begin
			if (hold_requests != holds_done) begin
				rsp_stall <= 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				holds_done++;
			end
			if ($urandom_range(0, 23) == 0) rx_quiet = !rx_quiet;
			gap = pick_gap(rx_quiet);
			if (gap > 0) begin
				rsp_stall <= 1'b1;
				repeat (gap) @(negedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (!(rsp_valid === 1'b1 && rsp_stall === 1'b0));
			sb.check_reply(rsp);
			@(negedge clk);
		end
	endtask

	initial begin
		@(posedge arst_n);
		@(negedge clk);
		serve_replies();
	end

	// Bound the run
	initial begin
		while (cycles < LIMIT_CYCLES) @(posedge clk) cycles = cycles + 1;
		$display("tb_top: FAIL");
		$finish;
	end

	initial begin
		int             first;
		int             pick;
		int             sel;
		logic [31:0]    size;
		session_fault_e fault;
		sb = new();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: bytes in idle, bad header, empty image through commit
		send_request(1'b1, 8'h00);
		send_request(1'b1, 8'hFF);
		run_session(0, FLT_DATA_HDR);
		run_session(0, FLT_NONE);

		// Back up the reply queue while session requests keep coming
		hold_requests++;
		repeat (BURST_ITEMS) send_request(1'b0, 8'($urandom));

		// Random sessions, aborted uploads and noise
		first = sent_items;
		while (sent_items - first < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 15) begin
				repeat ($urandom_range(1, 4))
					send_request($urandom_range(0, 7) != 0, 8'($urandom));
			end else if (pick < 25) begin
				send_request(1'b0, 8'($urandom));
				send_header(HDR_DATA_END, 1'b0);
				send_size($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'($urandom));
				repeat ($urandom_range(1, 8)) send_request(1'b1, 8'($urandom));
			end else begin
				sel = $urandom_range(0, 99);
				if (sel < 55) size = $urandom_range(1, 16);
				else if (sel < 70) size = 0;
				else if (sel < 90) size = $urandom_range(17, 64);
				else if (sel < 95) size = PAGE_BYTES;
				else size = $urandom_range(PAGE_BYTES + 1, PAGE_BYTES + 14);
				sel = $urandom_range(0, 9);
				case (sel)
					0: fault = FLT_DATA_HDR;
					1: fault = FLT_VERIFY_HDR;
					2, 3: fault = FLT_VERIFY_DATA;
					4: fault = FLT_COMMIT_HDR;
					5: fault = FLT_SKIP_COMMIT;
					default: fault = FLT_NONE;
				endcase
				run_session(size, fault);
			end
		end
		cmd_valid <= 1'b0;

		// Drain, then leave room for a trailing erase sweep
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("tb_top: %0d requests sent, %0d replies checked, %0d page acks",
			sb.requests, sb.checked, sb.pages);
		$display("tb_top: %0d commits, %0d aborted sessions, one long reply hold",
			sb.commits, sb.aborts);
		if (sb.errors == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule

/* filelist.f */
src/frx_pkg.sv
src/frx_ram.sv
src/frx_fifo.sv
src/frx_ctrl.sv
src/flash_update_receiver.sv
test/tb_top.sv
